>>> hw/rtl/ppt_pkg.sv
// Package for the packet protocol traffic counter.
// Holds class codes, header sizes, counter sizes and the shared payload types.
// No dependencies.
`timescale 1ns / 1ps

package ppt_pkg;

    localparam int NUM_CLASSES   = 10;
    localparam int COUNTER_WIDTH = 64;
    localparam int CLASS_IDX_W   = $clog2(NUM_CLASSES);

    localparam logic [3:0] CL_ALL   = 4'd0;
    localparam logic [3:0] CL_BCAST = 4'd1;
    localparam logic [3:0] CL_ARP   = 4'd2;
    localparam logic [3:0] CL_IPV4  = 4'd3;
    localparam logic [3:0] CL_IPV6  = 4'd4;
    localparam logic [3:0] CL_PPPOE = 4'd5;
    localparam logic [3:0] CL_ICMP  = 4'd6;
    localparam logic [3:0] CL_TCP   = 4'd7;
    localparam logic [3:0] CL_UDP   = 4'd8;
    localparam logic [3:0] CL_SCTP  = 4'd9;

    localparam logic [15:0] ET_ARP       = 16'h0806;
    localparam logic [15:0] ET_IPV4      = 16'h0800;
    localparam logic [15:0] ET_IPV6      = 16'h86DD;
    localparam logic [15:0] ET_PPPOE_DSC = 16'h8863;
    localparam logic [15:0] ET_PPPOE_SES = 16'h8864;

    localparam logic [7:0] PROTO_ICMP   = 8'd1;
    localparam logic [7:0] PROTO_ICMPV6 = 8'd58;
    localparam logic [7:0] PROTO_TCP    = 8'd6;
    localparam logic [7:0] PROTO_UDP    = 8'd17;
    localparam logic [7:0] PROTO_UDPLT  = 8'd136;
    localparam logic [7:0] PROTO_SCTP   = 8'd132;

    localparam logic [15:0] ETH_HDR_BYTES = 16'd14;
    localparam logic [15:0] IPV4_L4_OFS   = 16'd34;
    localparam logic [15:0] IPV6_L4_OFS   = 16'd54;

    localparam logic CMD_COUNT = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef enum logic [1:0] {
        LAYER_L2,
        LAYER_L3,
        LAYER_L4
    } layer_t;

    typedef struct packed {
        logic        cmd;
        logic [15:0] frame_len;
        logic        dest_group_bit;
        logic [15:0] ethertype;
        logic [7:0]  l3_next_proto;
        logic [3:0]  class_select;
    } req_t;

    typedef struct packed {
        logic [NUM_CLASSES-1:0] hit;
        logic [15:0]            len_l3;
        logic [15:0]            len_l4;
    } cls_t;

    // Header layer whose length a class counts; classes past sctp never hit.
    function automatic layer_t class_layer(input int idx);
        layer_t layer;
        layer = LAYER_L2;
        if (idx >= int'(CL_ICMP))
            layer = LAYER_L4;
        else if (idx >= int'(CL_ARP))
            layer = LAYER_L3;
        return layer;
    endfunction

endpackage

>>> hw/rtl/ppt_stream_if.sv
// Valid/ready channel interfaces for the traffic counter: request and response.
// Depends on nothing; payload fields are plain logic vectors.
`timescale 1ns / 1ps

interface ppt_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [15:0] frame_len;
    logic        dest_group_bit;
    logic [15:0] ethertype;
    logic [7:0]  l3_next_proto;
    logic [3:0]  class_select;

    modport source (output valid, cmd, frame_len, dest_group_bit, ethertype,
                    l3_next_proto, class_select, input ready);
    modport sink   (input valid, cmd, frame_len, dest_group_bit, ethertype,
                    l3_next_proto, class_select, output ready);
endinterface

interface ppt_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] packet_count;
    logic [63:0] byte_count;

    modport source (output valid, packet_count, byte_count, input ready);
    modport sink   (input valid, packet_count, byte_count, output ready);
endinterface

>>> hw/rtl/ppt_classifier.sv
// Frame classifier: turns one registered request into a class hit vector
// and the layer lengths to add. Depends on ppt_pkg.
`timescale 1ns / 1ps

module ppt_classifier
    import ppt_pkg::*;
(
    input  req_t item,
    output cls_t cls
);

    logic       long_enough;
    logic       is_ipv4;
    logic       is_ipv6;
    logic       l4_ok;
    logic [3:0] l3_code;
    logic [3:0] l4_code;
    logic       l3_hit;
    logic       l4_hit;

    // Pick the network layer class from the ethertype
    always_comb
    begin
        l3_hit  = 1'b1;
        l3_code = CL_ARP;
        case (item.ethertype)
            ET_ARP:                     l3_code = CL_ARP;
            ET_IPV4:                    l3_code = CL_IPV4;
            ET_IPV6:                    l3_code = CL_IPV6;
            ET_PPPOE_DSC, ET_PPPOE_SES: l3_code = CL_PPPOE;
            default:                    l3_hit  = 1'b0;
        endcase
    end

    // Pick the transport class from the protocol byte
    always_comb
    begin
        l4_hit  = 1'b1;
        l4_code = CL_ICMP;
        case (item.l3_next_proto)
            PROTO_ICMP, PROTO_ICMPV6: l4_code = CL_ICMP;
            PROTO_TCP:                l4_code = CL_TCP;
            PROTO_UDP, PROTO_UDPLT:   l4_code = CL_UDP;
            PROTO_SCTP:               l4_code = CL_SCTP;
            default:                  l4_hit  = 1'b0;
        endcase
    end

    assign long_enough = item.frame_len >= ETH_HDR_BYTES;
    assign is_ipv4     = l3_hit && (l3_code == CL_IPV4);
    assign is_ipv6     = l3_hit && (l3_code == CL_IPV6);
    assign l4_ok       = (is_ipv4 && (item.frame_len >= IPV4_L4_OFS)) ||
                         (is_ipv6 && (item.frame_len >= IPV6_L4_OFS));

    // Build hit vector and the per-layer byte amounts
    always_comb
    begin
        cls.hit = '0;
        if (long_enough)
        begin
            cls.hit[CL_ALL[CLASS_IDX_W-1:0]]   = 1'b1;
            cls.hit[CL_BCAST[CLASS_IDX_W-1:0]] = item.dest_group_bit;
            if (l3_hit)
                cls.hit[l3_code[CLASS_IDX_W-1:0]] = 1'b1;
            if (l4_ok && l4_hit)
                cls.hit[l4_code[CLASS_IDX_W-1:0]] = 1'b1;
        end
        cls.len_l3 = item.frame_len - ETH_HDR_BYTES;
        cls.len_l4 = is_ipv6 ? (item.frame_len - IPV6_L4_OFS)
                             : (item.frame_len - IPV4_L4_OFS);
    end

endmodule

>>> hw/rtl/packet_protocol_traffic_counter_unit.sv
// Top level of the per-protocol packet and byte counter.
// Depends on ppt_pkg, ppt_stream_if and ppt_classifier.
`timescale 1ns / 1ps

// Usage
// - req (sink): one transfer per frame descriptor or read command. cmd 0
//   counts a frame; cmd 1 reads both counters of class_select.
// - rsp (source): one transfer per read command with packet_count and
//   byte_count; count commands give no response.
// - Throughput: one request per cycle unless stalled. A request is captured
//   in an input register, then classified and added to the counters in the
//   next cycle; each class owns its own incrementers, so all hit classes
//   update at once.
// - Reads: a read loads the result register, which drives rsp.valid, once
//   that register is free; the read sees every count accepted before it.
// - Reset: all counters and both pipeline valid flags clear; counters read 0.
// - Stall: while rsp is held, the output register keeps its result; counts
//   keep flowing, and req.ready drops only when a read is waiting behind
//   the held result.
module packet_protocol_traffic_counter_unit
    import ppt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    ppt_req_if.sink   req,
    ppt_rsp_if.source rsp
);

    req_t                     stage_reg;
    logic                     stage_valid_reg;
    logic                     stage_valid_next;
    logic                     stage_done;
    logic                     in_xfer;
    logic                     is_read;
    logic                     do_count;
    cls_t                     cls;
    logic [COUNTER_WIDTH-1:0] pkt_cnt_reg  [NUM_CLASSES];
    logic [COUNTER_WIDTH-1:0] byte_cnt_reg [NUM_CLASSES];
    logic                     out_valid_reg;
    logic [63:0]              out_pkt_reg;
    logic [63:0]              out_byte_reg;
    logic [63:0]              rd_pkt;
    logic [63:0]              rd_byte;

    // Input stage advances unless a read is blocked by a held result
    assign is_read    = stage_reg.cmd == CMD_READ;
    assign stage_done = !is_read || !out_valid_reg || rsp.ready;
    assign req.ready  = !stage_valid_reg || stage_done;
    assign in_xfer    = req.valid && req.ready;
    assign do_count   = stage_valid_reg && !is_read;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (in_xfer)
            stage_valid_next = 1'b1;
        else if (stage_done)
            stage_valid_next = 1'b0;
    end

    // Hold the accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            stage_reg.cmd            <= req.cmd;
            stage_reg.frame_len      <= req.frame_len;
            stage_reg.dest_group_bit <= req.dest_group_bit;
            stage_reg.ethertype      <= req.ethertype;
            stage_reg.l3_next_proto  <= req.l3_next_proto;
            stage_reg.class_select   <= req.class_select;
        end
    end

    ppt_classifier u_classifier (
        .item (stage_reg),
        .cls  (cls)
    );

    // One pair of counters per class, each with its own adders
    for (genvar gi = 0; gi < NUM_CLASSES; gi++)
    begin : g_class
        localparam layer_t Layer = class_layer(gi);
        logic [15:0] amount;

        assign amount = (Layer == LAYER_L2) ? stage_reg.frame_len :
                        (Layer == LAYER_L3) ? cls.len_l3 : cls.len_l4;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                pkt_cnt_reg[gi]  <= '0;
                byte_cnt_reg[gi] <= '0;
            end
            else if (do_count && cls.hit[gi])
            begin
                pkt_cnt_reg[gi]  <= pkt_cnt_reg[gi] + COUNTER_WIDTH'(1);
                byte_cnt_reg[gi] <= byte_cnt_reg[gi] + COUNTER_WIDTH'(amount);
            end
        end
    end

    // Select the counters of the requested class; unused codes read zero
    always_comb
    begin
        rd_pkt  = '0;
        rd_byte = '0;
        if (32'(stage_reg.class_select) < NUM_CLASSES)
        begin
            rd_pkt  = 64'(pkt_cnt_reg[stage_reg.class_select[CLASS_IDX_W-1:0]]);
            rd_byte = 64'(byte_cnt_reg[stage_reg.class_select[CLASS_IDX_W-1:0]]);
        end
    end

    // Load result register on a read, drop it when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (stage_valid_reg && is_read && stage_done)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (stage_valid_reg && is_read && stage_done)
        begin
            out_pkt_reg  <= rd_pkt;
            out_byte_reg <= rd_byte;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.packet_count = out_pkt_reg;
    assign rsp.byte_count   = out_byte_reg;

endmodule

>>> hw/rtl/ppt_checker.sv
// Port-level checker for the traffic counter, bound to the top level.
// Depends only on the top level's port signals.
`timescale 1ns / 1ps

module ppt_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] packet_count,
    input logic [63:0] byte_count
);

    // A held result keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(packet_count) &&
        $stable(byte_count))
        else $error("response changed while stalled");

    // Input only stalls behind a stalled response
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("request stalled without response back-pressure");

    // A new response comes from a stage that was free to advance
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_ready))
        else $error("response appeared while input stage was blocked");

    // A response needs an earlier request
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid, 2) || !$past(in_ready, 2) ||
        $past(out_valid) || $past(in_valid, 3) || !$past(rst_n, 2))
        else $error("response without request");

endmodule

bind packet_protocol_traffic_counter_unit ppt_checker u_ppt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (req.valid),
    .in_ready     (req.ready),
    .out_valid    (rsp.valid),
    .out_ready    (rsp.ready),
    .packet_count (rsp.packet_count),
    .byte_count   (rsp.byte_count)
);

>>> test/testbench.sv
// Self-checking testbench for packet_protocol_traffic_counter_unit.
// Runs directed and random frame and read transfers, and checks every read
// response against a per-class counter predictor. Depends on ppt_pkg and ppt_stream_if.
`timescale 1ns / 1ps

module testbench;
    import ppt_pkg::*;

    localparam int RANDOM_ITEMS     = 480;
    localparam int CALM_ITEMS       = 60;
    localparam int LONG_HOLD_AFTER  = 40;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int DRAIN_CYCLES     = 10;
    localparam int CYCLE_LIMIT      = 200000;

    typedef struct {
        logic [63:0] packets;
        logic [63:0] octets;
    } readback_t;

    typedef struct {
        req_t        rq;
        bit          typed;
        logic [63:0] packets;
        logic [63:0] octets;
    } plan_row_t;

    logic clk;
    logic rst_n;

    ppt_req_if req_ch ();
    ppt_rsp_if rsp_ch ();

    packet_protocol_traffic_counter_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Predicted counter state, one pair per class
    logic [COUNTER_WIDTH-1:0] pkt_tally   [NUM_CLASSES];
    logic [COUNTER_WIDTH-1:0] octet_tally [NUM_CLASSES];

    readback_t readback_q [$];
    plan_row_t plan [$];

    int  mismatch_count = 0;
    int  reads_returned = 0;
    int  cycle_count    = 0;
    bit  calm           = 1'b0;
    bit  sender_gaps_on = 1'b1;
    bit  long_hold_done = 1'b0;

    // Clock: 20 ns period
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d reads still pending",
                     cycle_count, readback_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] mismatch: %s got 0x%016h expected 0x%016h",
                 $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic void bump_class(input logic [3:0] cls, input logic [15:0] bytes);
        pkt_tally[cls]   = pkt_tally[cls] + COUNTER_WIDTH'(1);
        octet_tally[cls] = octet_tally[cls] + COUNTER_WIDTH'(bytes);
    endfunction

    // Classify one frame and add it to every class it hits
    function automatic void tally_frame(input req_t r);
        logic [3:0]  l3_cls;
        logic [3:0]  l4_cls;
        logic        l3_hit;
        logic        l4_hit;
        logic [15:0] l4_ofs;
        if (r.frame_len < ETH_HDR_BYTES)
            return;
        bump_class(CL_ALL, r.frame_len);
        if (r.dest_group_bit)
            bump_class(CL_BCAST, r.frame_len);

        l3_hit = 1'b1;
        l3_cls = CL_ALL;
        case (r.ethertype)
            ET_ARP:                     l3_cls = CL_ARP;
            ET_IPV4:                    l3_cls = CL_IPV4;
            ET_IPV6:                    l3_cls = CL_IPV6;
            ET_PPPOE_DSC, ET_PPPOE_SES: l3_cls = CL_PPPOE;
            default:                    l3_hit = 1'b0;
        endcase
        if (l3_hit)
            bump_class(l3_cls, r.frame_len - ETH_HDR_BYTES);

        // Transport class only for IP frames long enough to hold the IP header
        l4_ofs = (l3_cls == CL_IPV6) ? IPV6_L4_OFS : IPV4_L4_OFS;
        if (!(l3_hit && (l3_cls == CL_IPV4 || l3_cls == CL_IPV6) && r.frame_len >= l4_ofs))
            return;
        l4_hit = 1'b1;
        l4_cls = CL_ALL;
        case (r.l3_next_proto)
            PROTO_ICMP, PROTO_ICMPV6: l4_cls = CL_ICMP;
            PROTO_TCP:                l4_cls = CL_TCP;
            PROTO_UDP, PROTO_UDPLT:   l4_cls = CL_UDP;
            PROTO_SCTP:               l4_cls = CL_SCTP;
            default:                  l4_hit = 1'b0;
        endcase
        if (l4_hit)
            bump_class(l4_cls, r.frame_len - l4_ofs);
    endfunction

    function automatic readback_t read_counters(input logic [3:0] sel);
        readback_t rb;
        rb.packets = '0;
        rb.octets  = '0;
        if (int'(sel) < NUM_CLASSES)
        begin
            rb.packets = 64'(pkt_tally[sel]);
            rb.octets  = 64'(octet_tally[sel]);
        end
        return rb;
    endfunction

    task automatic plan_row(input logic cmd, input logic [15:0] len, input logic grp,
                            input logic [15:0] et, input logic [7:0] proto,
                            input logic [3:0] sel, input bit typed,
                            input logic [63:0] packets, input logic [63:0] octets);
        plan_row_t row;
        row.rq.cmd            = cmd;
        row.rq.frame_len      = len;
        row.rq.dest_group_bit = grp;
        row.rq.ethertype      = et;
        row.rq.l3_next_proto  = proto;
        row.rq.class_select   = sel;
        row.typed             = typed;
        row.packets           = packets;
        row.octets            = octets;
        plan.push_back(row);
    endtask

    function automatic req_t random_request();
        req_t r;
        r.cmd            = ($urandom_range(0, 99) < 30) ? CMD_READ : CMD_COUNT;
        r.dest_group_bit = 1'($urandom);
        case ($urandom_range(0, 7))
            0:       r.frame_len = 16'($urandom_range(0, 13));
            1:       r.frame_len = 16'($urandom_range(30, 58));
            2:       r.frame_len = 16'hFFFF - 16'($urandom_range(0, 2));
            3:       r.frame_len = 16'($urandom);
            default: r.frame_len = 16'($urandom_range(14, 1518));
        endcase
        case ($urandom_range(0, 8))
            0:       r.ethertype = ET_ARP;
            1, 2:    r.ethertype = ET_IPV4;
            3, 4:    r.ethertype = ET_IPV6;
            5:       r.ethertype = ET_PPPOE_DSC;
            6:       r.ethertype = ET_PPPOE_SES;
            default: r.ethertype = 16'($urandom);
        endcase
        case ($urandom_range(0, 7))
            0:       r.l3_next_proto = PROTO_ICMP;
            1:       r.l3_next_proto = PROTO_ICMPV6;
            2:       r.l3_next_proto = PROTO_TCP;
            3:       r.l3_next_proto = PROTO_UDP;
            4:       r.l3_next_proto = PROTO_UDPLT;
            5:       r.l3_next_proto = PROTO_SCTP;
            default: r.l3_next_proto = 8'($urandom);
        endcase
        if (r.cmd == CMD_READ && $urandom_range(0, 7) != 0)
            r.class_select = 4'($urandom_range(0, NUM_CLASSES - 1));
        else
            r.class_select = 4'($urandom);
        return r;
    endfunction

    // Offer one request, hold it until the transfer, then update the predictor
    task automatic offer(input req_t r, input bit typed, input logic [63:0] packets,
                         input logic [63:0] octets);
        int gap;
        readback_t rb;
        gap = 0;
        if (!calm && sender_gaps_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 8);
        repeat (gap)
        begin
            @(negedge clk);
            req_ch.valid = 1'b0;
        end
        @(negedge clk);
        req_ch.cmd            = r.cmd;
        req_ch.frame_len      = r.frame_len;
        req_ch.dest_group_bit = r.dest_group_bit;
        req_ch.ethertype      = r.ethertype;
        req_ch.l3_next_proto  = r.l3_next_proto;
        req_ch.class_select   = r.class_select;
        req_ch.valid          = 1'b1;
        do
            @(posedge clk);
        while (!req_ch.ready);

        if (r.cmd == CMD_READ)
        begin
            rb = read_counters(r.class_select);
            if (typed)
            begin
                rb.packets = packets;
                rb.octets  = octets;
            end
            readback_q.push_back(rb);
        end
        else
            tally_frame(r);
    endtask

    // Check each response transfer against the oldest pending read
    always @(posedge clk)
    begin : rsp_check
        readback_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (readback_q.size() == 0)
                report_mismatch("response with no read pending", rsp_ch.packet_count, '0);
            else
            begin
                want = readback_q.pop_front();
                if (rsp_ch.packet_count !== want.packets)
                    report_mismatch("packet_count", rsp_ch.packet_count, want.packets);
                if (rsp_ch.byte_count !== want.octets)
                    report_mismatch("byte_count", rsp_ch.byte_count, want.octets);
            end
            reads_returned++;
        end
    end

    // Response ready: random stall bursts, one long hold-off, none at the end
    initial
    begin : rsp_pacing
        int stall_left;
        int seg_left;
        bit stalls_on;
        stall_left = 0;
        seg_left   = 0;
        stalls_on  = 1'b1;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!long_hold_done && reads_returned >= LONG_HOLD_AFTER)
            begin
                rsp_ch.ready = 1'b0;
                repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
                long_hold_done = 1'b1;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    seg_left  = 48;
                    stalls_on = ($urandom_range(0, 2) != 0);
                end
                seg_left--;
                if (stall_left == 0 && stalls_on && !calm && $urandom_range(0, 4) == 0)
                    stall_left = $urandom_range(1, 8);
                if (stall_left != 0)
                begin
                    rsp_ch.ready = 1'b0;
                    stall_left--;
                end
                else
                    rsp_ch.ready = 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        req_t r;
        int   n;
        for (n = 0; n < NUM_CLASSES; n++)
        begin
            pkt_tally[n]   = '0;
            octet_tally[n] = '0;
        end
        req_ch.valid          = 1'b0;
        req_ch.cmd            = CMD_COUNT;
        req_ch.frame_len      = '0;
        req_ch.dest_group_bit = 1'b0;
        req_ch.ethertype      = '0;
        req_ch.l3_next_proto  = '0;
        req_ch.class_select   = '0;

        // Hold reset, then release it at a falling clock edge
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset state, short frames, each class and length edge
        plan_row(CMD_READ,  16'hFFFF, 1'b1, ET_IPV4, 8'hFF, CL_ALL, 1'b1, '0, '0);
        plan_row(CMD_COUNT, 16'd0,    1'b1, ET_IPV4, PROTO_TCP, CL_ALL, 1'b0, '0, '0);
        plan_row(CMD_COUNT, 16'd13,   1'b1, ET_IPV6, PROTO_UDP, CL_ALL, 1'b0, '0, '0);
        plan_row(CMD_READ,  16'd0,    1'b0, 16'h0,   8'h0, CL_ALL, 1'b1, '0, '0);
        plan_row(CMD_COUNT, 16'd14,   1'b0, ET_ARP,  PROTO_TCP, CL_ALL, 1'b0, '0, '0);
        plan_row(CMD_COUNT, 16'hFFFF, 1'b1, ET_IPV6, PROTO_ICMPV6, CL_ALL, 1'b0, '0, '0);
        plan_row(CMD_COUNT, 16'd33,   1'b0, ET_IPV4, PROTO_TCP, CL_ALL, 1'b0, '0, '0);
        plan_row(CMD_COUNT, 16'd34,   1'b0, ET_IPV4, PROTO_ICMP, CL_ALL, 1'b0, '0, '0);
        plan_row(CMD_COUNT, 16'd53,   1'b0, ET_IPV6, PROTO_UDP, CL_ALL, 1'b0, '0, '0);
        plan_row(CMD_COUNT, 16'd54,   1'b1, ET_IPV6, PROTO_UDPLT, CL_ALL, 1'b0, '0, '0);
        plan_row(CMD_COUNT, 16'd200,  1'b0, ET_IPV4, PROTO_SCTP, CL_ALL, 1'b0, '0, '0);
        plan_row(CMD_COUNT, 16'd300,  1'b0, ET_PPPOE_DSC, 8'hFF, CL_ALL, 1'b0, '0, '0);
        plan_row(CMD_COUNT, 16'd400,  1'b1, ET_PPPOE_SES, PROTO_TCP, CL_ALL, 1'b0, '0, '0);
        plan_row(CMD_COUNT, 16'd1500, 1'b0, ET_IPV4, PROTO_TCP, 4'hF, 1'b0, '0, '0);
        plan_row(CMD_COUNT, 16'd500,  1'b1, 16'hFFFF, PROTO_UDP, CL_ALL, 1'b0, '0, '0);
        for (n = 0; n < NUM_CLASSES; n++)
            plan_row(CMD_READ, 16'hA5A5, n[0], ET_IPV4, PROTO_TCP, 4'(n), 1'b0, '0, '0);
        plan_row(CMD_READ,  16'd64, 1'b1, ET_IPV4, PROTO_TCP, 4'(NUM_CLASSES), 1'b1, '0, '0);
        plan_row(CMD_READ,  16'd64, 1'b0, ET_ARP,  PROTO_UDP, 4'hF, 1'b1, '0, '0);

        foreach (plan[i])
            offer(plan[i].rq, plan[i].typed, plan[i].packets, plan[i].octets);

        // Random traffic, gaps switched on and off in segments
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            calm = (n >= RANDOM_ITEMS - CALM_ITEMS);
            if (n % 32 == 0)
                sender_gaps_on = ($urandom_range(0, 2) != 0);
            // Hold off midway until every pending read has returned
            if (n == RANDOM_ITEMS / 2)
            begin
                @(negedge clk);
                req_ch.valid = 1'b0;
                while (readback_q.size() != 0)
                    @(posedge clk);
            end
            r = random_request();
            offer(r, 1'b0, '0, '0);
        end

        // Drain outstanding reads, then let the pipeline settle
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (readback_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/ppt_pkg.sv
hw/rtl/ppt_stream_if.sv
hw/rtl/ppt_classifier.sv
hw/rtl/packet_protocol_traffic_counter_unit.sv
hw/rtl/ppt_checker.sv
test/testbench.sv
